[design/abm_pkg.sv]
// Shared types and constants for the audio block level meter.
// Used by every module under design/; depends on nothing.
package abm_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int MAX_FRAMES  = 4096;

    localparam int MAG_W    = SAMPLE_BITS;
    localparam int CNT_W    = $clog2(MAX_FRAMES + 1);
    localparam int SQ_W     = 2 * SAMPLE_BITS - 1;
    localparam int SQSUM_W  = SQ_W + CNT_W - 1;
    localparam int SUM_W    = SAMPLE_BITS + CNT_W;
    localparam int RAD_W    = 2 * SAMPLE_BITS;
    localparam int ROOT_W   = SAMPLE_BITS;
    localparam int SREM_W   = ROOT_W + 1;
    localparam int TRIAL_W  = SREM_W + 3;
    localparam int STEP_W   = $clog2(SQSUM_W);
    localparam int Q_DEPTH  = 2;
    localparam int QPTR_W   = $clog2(Q_DEPTH);
    localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [MAG_W-1:0] FULL_SCALE = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } t_in;

    typedef struct packed {
        logic        [MAG_W-1:0]       peak;
        logic        [MAG_W-1:0]       trough;
        logic        [MAG_W-1:0]       rms;
        logic signed [SAMPLE_BITS-1:0] dc_offset;
    } t_out;

    // One finished buffer, handed from the accumulator to the divide/root engine
    typedef struct packed {
        logic        [MAG_W-1:0]   peak;
        logic        [MAG_W-1:0]   trough;
        logic        [SQSUM_W-1:0] sq_sum;
        logic signed [SUM_W-1:0]   sum;
        logic        [CNT_W-1:0]   count;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIVSQ = 5'b00010,
        ST_DIVDC = 5'b00100,
        ST_SQRT  = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

endpackage

[design/abm_front.sv]
// Sample front end: magnitude, square and per-buffer accumulation.
// Pushes one job per ended buffer into the job queue. Depends on abm_pkg.
module abm_front
    import abm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_data,
    output logic o_stall,
    input  logic i_q_full,
    output logic o_push,
    output t_job o_job
);

    logic                          r_s1_valid;
    logic signed [SAMPLE_BITS-1:0] r_s1_value;
    logic        [MAG_W-1:0]       r_s1_mag;
    logic                          r_s1_last;

    logic                          r_s2_valid;
    logic signed [SAMPLE_BITS-1:0] r_s2_value;
    logic        [MAG_W-1:0]       r_s2_mag;
    logic        [SQ_W-1:0]        r_s2_sq;
    logic                          r_s2_last;

    logic        [MAG_W-1:0]       r_peak;
    logic        [MAG_W-1:0]       r_trough;
    logic        [SQSUM_W-1:0]     r_sq_sum;
    logic signed [SUM_W-1:0]       r_sum;
    logic        [CNT_W-1:0]       r_count;

    logic        [MAG_W-1:0]       mag_in;
    logic        [2*MAG_W-1:0]     prod;
    logic        [CNT_W-1:0]       n_count;
    logic        [MAG_W-1:0]       n_peak;
    logic        [MAG_W-1:0]       n_trough;
    logic        [SQSUM_W-1:0]     n_sq_sum;
    logic signed [SUM_W-1:0]       n_sum;
    logic                          s2_end;
    logic                          advance;

    always_comb begin
        if (i_data.sample[SAMPLE_BITS-1]) begin
            mag_in = MAG_W'($unsigned(~i_data.sample) + MAG_W'(1));
        end else begin
            mag_in = MAG_W'($unsigned(i_data.sample));
        end
        prod     = r_s1_mag * r_s1_mag;
        n_count  = r_count + CNT_W'(1);
        n_peak   = (r_s2_mag > r_peak) ? r_s2_mag : r_peak;
        n_trough = (r_s2_mag < r_trough) ? r_s2_mag : r_trough;
        n_sq_sum = r_sq_sum + SQSUM_W'(r_s2_sq);
        n_sum    = r_sum + SUM_W'(r_s2_value);
        s2_end   = r_s2_valid && (r_s2_last || (n_count == CNT_W'(MAX_FRAMES)));
        // hold the whole pipe when an ending buffer finds the queue full
        advance  = !(s2_end && i_q_full);
    end

    assign o_stall      = !advance;
    assign o_push       = s2_end && advance;
    assign o_job.peak   = n_peak;
    assign o_job.trough = n_trough;
    assign o_job.sq_sum = n_sq_sum;
    assign o_job.sum    = n_sum;
    assign o_job.count  = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_peak     <= '0;
            r_trough   <= FULL_SCALE;
            r_sq_sum   <= '0;
            r_sum      <= '0;
            r_count    <= '0;
        end else if (advance) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            if (r_s2_valid) begin
                if (s2_end) begin
                    r_peak   <= '0;
                    r_trough <= FULL_SCALE;
                    r_sq_sum <= '0;
                    r_sum    <= '0;
                    r_count  <= '0;
                end else begin
                    r_peak   <= n_peak;
                    r_trough <= n_trough;
                    r_sq_sum <= n_sq_sum;
                    r_sum    <= n_sum;
                    r_count  <= n_count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_value <= i_data.sample;
            r_s1_mag   <= mag_in;
            r_s1_last  <= i_data.last;
            r_s2_value <= r_s1_value;
            r_s2_mag   <= r_s1_mag;
            r_s2_sq    <= prod[SQ_W-1:0];
            r_s2_last  <= r_s1_last;
        end
    end

endmodule

[design/abm_queue.sv]
// Short job queue between the accumulator and the divide/root engine.
// Depends on abm_pkg for the job type and depth.
module abm_queue
    import abm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    t_job              r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_fill;

    assign o_job        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_fill == QCNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_fill == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

[design/abm_back.sv]
// Divide/root engine: one shared radix-2 divider for mean square and DC,
// a bit-pair square root, and the output register. Depends on abm_pkg.
module abm_back
    import abm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_job i_job,
    input  logic i_q_empty,
    output logic o_pop,
    output logic o_valid,
    output t_out o_data,
    input  logic i_stall
);

    t_state                  r_state;
    t_state                  n_state;
    logic [STEP_W-1:0]       r_step;
    logic [MAG_W-1:0]        r_peak;
    logic [MAG_W-1:0]        r_trough;
    logic [CNT_W-1:0]        r_count;
    logic                    r_neg;
    logic [SUM_W-1:0]        r_dc_mag;
    logic [SQSUM_W-1:0]      r_quo;
    logic [CNT_W-1:0]        r_rem;
    logic [RAD_W-1:0]        r_rad;
    logic [MAG_W-1:0]        r_dc_q;
    logic [ROOT_W-1:0]       r_root;
    logic [SREM_W-1:0]       r_srem;
    logic                    r_out_valid;
    t_out                    r_out;

    logic [CNT_W:0]          div_shift;
    logic                    div_ge;
    logic [CNT_W:0]          div_diff;
    logic [CNT_W-1:0]        n_rem;
    logic [SQSUM_W-1:0]      n_quo;
    logic [TRIAL_W-1:0]      sq_a;
    logic [TRIAL_W-1:0]      sq_diff;
    logic                    sq_ge;
    logic [SREM_W-1:0]       n_srem;
    logic [ROOT_W-1:0]       n_root;
    logic                    div_last;
    logic                    sqrt_last;
    logic                    out_load;
    logic [MAG_W-1:0]        dc_out;

    always_comb begin
        // restoring divide step: bring down one dividend bit, subtract if it fits
        div_shift = {r_rem, r_quo[SQSUM_W-1]};
        div_diff  = div_shift - {1'b0, r_count};
        div_ge    = (div_shift >= {1'b0, r_count});
        n_rem     = div_ge ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
        n_quo     = {r_quo[SQSUM_W-2:0], div_ge};

        // square root step: bring down two radicand bits, try 4*root+1
        sq_a      = {1'b0, r_srem, r_rad[RAD_W-1 -: 2]};
        sq_diff   = sq_a - TRIAL_W'({r_root, 2'b01});
        sq_ge     = !sq_diff[TRIAL_W-1];
        n_srem    = sq_ge ? sq_diff[SREM_W-1:0] : sq_a[SREM_W-1:0];
        n_root    = {r_root[ROOT_W-2:0], sq_ge};

        div_last  = (r_step == STEP_W'(SQSUM_W - 1));
        sqrt_last = (r_step == STEP_W'(ROOT_W - 1));
        out_load  = (r_state == ST_DONE) && (!r_out_valid || !i_stall);
        o_pop     = (r_state == ST_IDLE) && !i_q_empty;
        dc_out    = r_neg ? (~r_dc_q + MAG_W'(1)) : r_dc_q;

        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = ST_DIVSQ;
                end
            end
            ST_DIVSQ: begin
                if (div_last) begin
                    n_state = ST_DIVDC;
                end
            end
            ST_DIVDC: begin
                if (div_last) begin
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (sqrt_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE || div_last || (r_state == ST_SQRT && sqrt_last)) begin
                r_step <= '0;
            end else begin
                r_step <= r_step + STEP_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_peak   <= i_job.peak;
                r_trough <= i_job.trough;
                r_count  <= i_job.count;
                r_neg    <= i_job.sum[SUM_W-1];
                r_dc_mag <= i_job.sum[SUM_W-1] ? ($unsigned(~i_job.sum) + SUM_W'(1))
                                               : $unsigned(i_job.sum);
                r_quo    <= i_job.sq_sum;
                r_rem    <= '0;
            end
            ST_DIVSQ: begin
                if (div_last) begin
                    // mean square never exceeds full scale squared
                    r_rad <= n_quo[RAD_W-1:0];
                    r_quo <= SQSUM_W'(r_dc_mag);
                    r_rem <= '0;
                end else begin
                    r_quo <= n_quo;
                    r_rem <= n_rem;
                end
            end
            ST_DIVDC: begin
                if (div_last) begin
                    r_dc_q <= n_quo[MAG_W-1:0];
                    r_root <= '0;
                    r_srem <= '0;
                end else begin
                    r_quo <= n_quo;
                    r_rem <= n_rem;
                end
            end
            ST_SQRT: begin
                r_root <= n_root;
                r_srem <= n_srem;
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out.peak      <= r_peak;
            r_out.trough    <= r_trough;
            r_out.rms       <= r_root;
            r_out.dc_offset <= $signed(dc_out);
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

[design/audio_block_level_meter.sv]
// Top level of the audio block level meter: front end, job queue, back end.
// Depends on abm_pkg, abm_front, abm_queue and abm_back.
//
//   channel | direction | handshake          | beat payload
//   --------+-----------+--------------------+-----------------------------------
//   input   | in        | i_valid / o_stall  | i_data : sample (Q1.23), last
//   output  | out       | o_valid / i_stall  | o_data : peak, trough, rms, dc_offset
//
// Flow: the front end takes one sample beat per cycle unless o_stall holds it; a
// sample passes the s1 and s2 registers before it reaches the accumulators. For
// each ended buffer the back end loads the job, runs 59 divide steps for the mean
// square and 59 for the DC offset on the shared one-bit-per-cycle divider, takes
// 24 square root steps, and loads the output.
// The two-entry job queue lets sampling run on while the back end works.
// Reset: synchronous, active low; clears pipeline valids, accumulators,
// queue pointers, the back end state and the output valid.
// Stalls: o_stall rises only when a buffer ends and the job queue is full;
// i_stall holds the output register, and the back end waits in its final state.
module audio_block_level_meter
    import abm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_data,
    output logic o_stall,
    output logic o_valid,
    output t_out o_data,
    input  logic i_stall
);

    logic    push;
    logic    pop;
    t_job    job_in;
    t_job    job_out;
    t_q_stat q_stat;

    // accumulate samples, emit a job per ended buffer
    abm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_data   (i_data),
        .o_stall  (o_stall),
        .i_q_full (q_stat.full),
        .o_push   (push),
        .o_job    (job_in)
    );

    // decouple sampling from the slow per-buffer math
    abm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_stat  (q_stat)
    );

    // divide, take the root, and present the result beat
    abm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (job_out),
        .i_q_empty (q_stat.empty),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .i_stall   (i_stall)
    );

    // never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("job pushed into full queue");

    // never pop an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("job popped from empty queue");

    // levels stay within full scale, and RMS never tops the peak
    a_levels_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.peak <= FULL_SCALE) && (o_data.trough <= FULL_SCALE)
                    && (o_data.rms <= o_data.peak))
        else $error("result levels out of range");

    // a queue that a push has just filled, and that is not popped, takes no further push
    a_stall_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_stat.full && !pop && $past(push)) |-> !push)
        else $error("push while queue held full");

endmodule
